@@ hdl/ept_pkg.sv @@
// Package for the pose-to-transform block: payload types, CORDIC constants
// and the arctangent table. No dependencies.
package ept_pkg;

    localparam int CordicStagesDef = 14;
    localparam int CordicW = 34;

    localparam logic signed [CordicW-1:0] Q30Pi     = 34'sd3373259426;
    localparam logic signed [CordicW-1:0] Q30HalfPi = 34'sd1686629713;
    localparam logic signed [CordicW-1:0] Q30InvK   = 34'sd652032874;

    typedef struct packed {
        logic signed [15:0] roll_angle;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] yaw_angle;
        logic signed [31:0] x_pos;
        logic signed [31:0] y_pos;
        logic signed [31:0] z_pos;
    } t_pose;

    typedef struct packed {
        logic signed [15:0] r00;
        logic signed [15:0] r01;
        logic signed [15:0] r02;
        logic signed [15:0] r10;
        logic signed [15:0] r11;
        logic signed [15:0] r12;
        logic signed [15:0] r20;
        logic signed [15:0] r21;
        logic signed [15:0] r22;
        logic signed [31:0] tx;
        logic signed [31:0] ty;
        logic signed [31:0] tz;
    } t_xform;

    // round(atan(2^-i) * 2^30)
    function automatic logic signed [CordicW-1:0] atan_q30(input int i);
        logic signed [CordicW-1:0] t;
        case (i)
            0:  t = 34'sd843314857;
            1:  t = 34'sd497837829;
            2:  t = 34'sd263043837;
            3:  t = 34'sd133525159;
            4:  t = 34'sd67021687;
            5:  t = 34'sd33543516;
            6:  t = 34'sd16775851;
            7:  t = 34'sd8388437;
            8:  t = 34'sd4194283;
            9:  t = 34'sd2097149;
            10: t = 34'sd1048576;
            11: t = 34'sd524288;
            12: t = 34'sd262144;
            13: t = 34'sd131072;
            14: t = 34'sd65536;
            15: t = 34'sd32768;
            16: t = 34'sd16384;
            17: t = 34'sd8192;
            18: t = 34'sd4096;
            19: t = 34'sd2048;
            20: t = 34'sd1024;
            21: t = 34'sd512;
            22: t = 34'sd256;
            23: t = 34'sd128;
            default: t = '0;
        endcase
        return t;
    endfunction

endpackage

@@ hdl/ept_cordic.sv @@
// Pipelined rotation-mode CORDIC: sine and cosine of one Q2.13 angle in Q.30.
// Depends on ept_pkg. One stage per iteration plus a quadrant-fold stage.
module ept_cordic #(
    parameter int CORDIC_STAGES = ept_pkg::CordicStagesDef
) (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic signed [15:0]                 i_angle,
    output logic signed [ept_pkg::CordicW-1:0] o_sin,
    output logic signed [ept_pkg::CordicW-1:0] o_cos
);
    localparam int W = ept_pkg::CordicW;

    logic signed [W-1:0] r_x [CORDIC_STAGES+1];
    logic signed [W-1:0] r_y [CORDIC_STAGES+1];
    logic signed [W-1:0] r_z [CORDIC_STAGES+1];
    logic                r_neg [CORDIC_STAGES+1];
    logic signed [W-1:0] n_z0;
    logic                n_neg0;
    logic signed [W-1:0] w_a;

    always_comb begin
        w_a    = W'({{(W-16){i_angle[15]}}, i_angle} <<< 17);
        n_z0   = w_a;
        n_neg0 = 1'b0;
        if (w_a > ept_pkg::Q30HalfPi) begin
            n_z0 = w_a - ept_pkg::Q30Pi; n_neg0 = 1'b1;
        end else if (w_a < -ept_pkg::Q30HalfPi) begin
            n_z0 = w_a + ept_pkg::Q30Pi; n_neg0 = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]   <= ept_pkg::Q30InvK;
            r_y[0]   <= '0;
            r_z[0]   <= n_z0;
            r_neg[0] <= n_neg0;
        end
    end

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_neg[g+1] <= r_neg[g];
                if (!r_z[g][W-1]) begin
                    r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] - ept_pkg::atan_q30(g);
                end else begin
                    r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] + ept_pkg::atan_q30(g);
                end
            end
        end
    end

    assign o_sin = r_neg[CORDIC_STAGES] ? -r_y[CORDIC_STAGES] : r_y[CORDIC_STAGES];
    assign o_cos = r_neg[CORDIC_STAGES] ? -r_x[CORDIC_STAGES] : r_x[CORDIC_STAGES];
endmodule

@@ hdl/euler_pose_to_transform_top.sv @@
// Top level of the pose-to-transform block: three CORDICs, product stages,
// rounding and the output register. Depends on ept_pkg and ept_cordic.
//
// Usage: a pose request (roll, pitch, yaw in Q2.13, position in Q16.16)
// enters on i_in_valid/o_in_ready; the transform (nine Q1.14 rotation
// entries, translation copied from the position) leaves on
// o_out_valid/i_out_ready. One request may enter every cycle while o_in_ready is high.
// The path runs through one fold stage and CORDIC_STAGES iteration stages
// in each CORDIC, two product stages (the second product layer needs the
// first), and one sum-and-round stage that loads the output register.
// The whole pipe advances as one: it moves whenever the output register is
// empty or being taken. When the receiver stalls with a result waiting, the
// pipe freezes, o_in_ready drops, and nothing is lost or repeated; bubbles
// inside the pipe are not squeezed out but move along with the data, and
// the pipe also advances when the output is empty. Reset clears all valid
// bits; data registers are not reset. Every request gives exactly one result.
module euler_pose_to_transform_top #(
    parameter int CORDIC_STAGES = ept_pkg::CordicStagesDef
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  ept_pkg::t_pose  i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output ept_pkg::t_xform o_out_data
);
    localparam int W = ept_pkg::CordicW;
    localparam int Lat = CORDIC_STAGES + 3;  // stages before output register

    logic w_adv;
    logic [Lat-1:0] r_vld;
    logic signed [31:0] r_tx [Lat], r_ty [Lat], r_tz [Lat];

    assign w_adv      = !o_out_valid || i_out_ready;
    assign o_in_ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[Lat-2:0], i_in_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_tx[0] <= i_in_data.x_pos;
            r_ty[0] <= i_in_data.y_pos;
            r_tz[0] <= i_in_data.z_pos;
            for (int k = 1; k < Lat; k++) begin
                r_tx[k] <= r_tx[k-1];
                r_ty[k] <= r_ty[k-1];
                r_tz[k] <= r_tz[k-1];
            end
        end
    end

    logic signed [W-1:0] w_sa, w_ca, w_sb, w_cb, w_sg, w_cg;

    ept_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_yaw (
        .i_clk(i_clk), .i_en(w_adv), .i_angle(i_in_data.yaw_angle),
        .o_sin(w_sa), .o_cos(w_ca));
    ept_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_pitch (
        .i_clk(i_clk), .i_en(w_adv), .i_angle(i_in_data.pitch_angle),
        .o_sin(w_sb), .o_cos(w_cb));
    ept_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_roll (
        .i_clk(i_clk), .i_en(w_adv), .i_angle(i_in_data.roll_angle),
        .o_sin(w_sg), .o_cos(w_cg));

    // Q.30 product with rounding; magnitudes stay near 2^30, so the 34-bit result holds it.
    function automatic logic signed [W-1:0] mul30(
        input logic signed [W-1:0] p, input logic signed [W-1:0] q);
        logic signed [2*W-1:0] m;
        m = p * q + (64'sd1 <<< 29);
        return W'(m >>> 30);
    endfunction

    function automatic logic signed [15:0] to_q14(input logic signed [W-1:0] v);
        logic signed [W-1:0] r;
        r = (v + W'(32768)) >>> 16;
        if (r > W'(16384)) r = W'(16384);
        else if (r < -W'(16384)) r = -W'(16384);
        return 16'(r);
    endfunction

    // First product stage.
    logic signed [W-1:0] r_casb, r_sasb, r_cacb, r_sacb, r_sacg, r_sasg,
                         r_cacg, r_casg, r_cbsg, r_cbcg, r_nsb, r_sg1, r_cg1;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_casb <= mul30(w_ca, w_sb);
            r_sasb <= mul30(w_sa, w_sb);
            r_cacb <= mul30(w_ca, w_cb);
            r_sacb <= mul30(w_sa, w_cb);
            r_sacg <= mul30(w_sa, w_cg);
            r_sasg <= mul30(w_sa, w_sg);
            r_cacg <= mul30(w_ca, w_cg);
            r_casg <= mul30(w_ca, w_sg);
            r_cbsg <= mul30(w_cb, w_sg);
            r_cbcg <= mul30(w_cb, w_cg);
            r_nsb  <= -w_sb;
            r_sg1  <= w_sg;
            r_cg1  <= w_cg;
        end
    end

    // Second product stage.
    logic signed [W-1:0] r_p01, r_p02, r_p11, r_p12;
    logic signed [W-1:0] r2_sacg, r2_sasg, r2_cacg, r2_casg;
    logic signed [W-1:0] r2_cacb, r2_sacb, r2_nsb, r2_cbsg, r2_cbcg;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p01   <= mul30(r_casb, r_sg1);
            r_p02   <= mul30(r_casb, r_cg1);
            r_p11   <= mul30(r_sasb, r_sg1);
            r_p12   <= mul30(r_sasb, r_cg1);
            r2_sacg <= r_sacg;
            r2_sasg <= r_sasg;
            r2_cacg <= r_cacg;
            r2_casg <= r_casg;
            r2_cacb <= r_cacb;
            r2_sacb <= r_sacb;
            r2_nsb  <= r_nsb;
            r2_cbsg <= r_cbsg;
            r2_cbcg <= r_cbcg;
        end
    end

    // Sum, round and saturate, then the output register.
    ept_pkg::t_xform r_out;
    logic            r_out_vld;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out.r00 <= to_q14(r2_cacb);
            r_out.r01 <= to_q14(r_p01 - r2_sacg);
            r_out.r02 <= to_q14(r_p02 + r2_sasg);
            r_out.r10 <= to_q14(r2_sacb);
            r_out.r11 <= to_q14(r_p11 + r2_cacg);
            r_out.r12 <= to_q14(r_p12 - r2_casg);
            r_out.r20 <= to_q14(r2_nsb);
            r_out.r21 <= to_q14(r2_cbsg);
            r_out.r22 <= to_q14(r2_cbcg);
            r_out.tx  <= r_tx[Lat-1];
            r_out.ty  <= r_ty[Lat-1];
            r_out.tz  <= r_tz[Lat-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= r_vld[Lat-1];
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;
endmodule
